// ===== hw/rtl/fmr_pkg.sv =====
// Shared types, constants and the control program of the fraction multiply/reduce block.
package fmr_pkg;

  // Default fraction register width and fixed transaction field widths.
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CMD_W           = 2;
  localparam int OPNUM_W         = 32;
  localparam int OPDEN_W         = 31;
  localparam int RES_W           = 32;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_MUL    = 2'd1,
    CMD_REDUCE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Datapath operations selected by the control word.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_GCD_INIT,
    OP_DIVG_INIT,
    OP_DIV_STEP,
    OP_GCD_SHIFT,
    OP_SET_MARK,
    OP_MULN_INIT,
    OP_MUL_STEP,
    OP_MULN_DONE,
    OP_MULD_INIT,
    OP_MULD_DONE,
    OP_CLEAR_MARK,
    OP_DIVN_INIT,
    OP_DIVN_DONE,
    OP_DIVD_INIT,
    OP_DIVD_DONE
  } op_t;

  // Jump conditions; a step whose condition fails falls through.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_CNT_MORE,
    C_A_ZERO,
    C_B_ZERO,
    C_MARK_SET,
    C_MARK_CLEAR
  } cond_t;

  localparam int PC_W = 5;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic accept;
    logic run;
    op_t  op;
  } dp_ctrl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic cnt_more;
    logic mark;
  } dp_status_t;

  // Program addresses.
  localparam int L_LOAD      = 0;
  localparam int L_LOAD_GCD  = 2;
  localparam int L_LOAD_DIV  = 3;
  localparam int L_LOAD_END  = 5;
  localparam int L_MUL       = 6;
  localparam int L_MULN_LOOP = 7;
  localparam int L_MULD_LOOP = 10;
  localparam int L_MUL_GCD   = 13;
  localparam int L_MUL_DIV   = 14;
  localparam int L_MUL_END   = 16;
  localparam int L_DONE      = 17;
  localparam int L_RED       = 18;
  localparam int L_RED_GCD   = 20;
  localparam int L_RED_DIV   = 21;
  localparam int L_RED_G     = 23;
  localparam int L_DIVN_LOOP = 25;
  localparam int L_DIVD_LOOP = 28;

  function automatic ucode_t uw(op_t op, cond_t cond, int target, logic last);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = PC_W'(target);
    w.last   = last;
    return w;
  endfunction

  // The control program. Each gcd is an Euclidean loop over the shared divider.
  function automatic ucode_t ucode(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      // Load: set the fraction, then mark it when the gcd exceeds one.
      5'd0:    w = uw(OP_LOAD,       C_NEXT,       0,           1'b0);
      5'd1:    w = uw(OP_GCD_INIT,   C_NEXT,       0,           1'b0);
      5'd2:    w = uw(OP_DIVG_INIT,  C_B_ZERO,     L_LOAD_END,  1'b0);
      5'd3:    w = uw(OP_DIV_STEP,   C_CNT_MORE,   L_LOAD_DIV,  1'b0);
      5'd4:    w = uw(OP_GCD_SHIFT,  C_ALWAYS,     L_LOAD_GCD,  1'b0);
      5'd5:    w = uw(OP_SET_MARK,   C_NEXT,       0,           1'b1);
      // Multiply: numerator product, denominator product, optional gcd.
      5'd6:    w = uw(OP_MULN_INIT,  C_NEXT,       0,           1'b0);
      5'd7:    w = uw(OP_MUL_STEP,   C_CNT_MORE,   L_MULN_LOOP, 1'b0);
      5'd8:    w = uw(OP_MULN_DONE,  C_NEXT,       0,           1'b0);
      5'd9:    w = uw(OP_MULD_INIT,  C_NEXT,       0,           1'b0);
      5'd10:   w = uw(OP_MUL_STEP,   C_CNT_MORE,   L_MULD_LOOP, 1'b0);
      5'd11:   w = uw(OP_MULD_DONE,  C_MARK_SET,   L_DONE,      1'b0);
      5'd12:   w = uw(OP_GCD_INIT,   C_NEXT,       0,           1'b0);
      5'd13:   w = uw(OP_DIVG_INIT,  C_B_ZERO,     L_MUL_END,   1'b0);
      5'd14:   w = uw(OP_DIV_STEP,   C_CNT_MORE,   L_MUL_DIV,   1'b0);
      5'd15:   w = uw(OP_GCD_SHIFT,  C_ALWAYS,     L_MUL_GCD,   1'b0);
      5'd16:   w = uw(OP_SET_MARK,   C_NEXT,       0,           1'b1);
      // Common exit with no state change.
      5'd17:   w = uw(OP_NOP,        C_NEXT,       0,           1'b1);
      // Reduce: only when marked; divide both parts by a nonzero gcd.
      5'd18:   w = uw(OP_NOP,        C_MARK_CLEAR, L_DONE,      1'b0);
      5'd19:   w = uw(OP_GCD_INIT,   C_NEXT,       0,           1'b0);
      5'd20:   w = uw(OP_DIVG_INIT,  C_B_ZERO,     L_RED_G,     1'b0);
      5'd21:   w = uw(OP_DIV_STEP,   C_CNT_MORE,   L_RED_DIV,   1'b0);
      5'd22:   w = uw(OP_GCD_SHIFT,  C_ALWAYS,     L_RED_GCD,   1'b0);
      5'd23:   w = uw(OP_CLEAR_MARK, C_A_ZERO,     L_DONE,      1'b0);
      5'd24:   w = uw(OP_DIVN_INIT,  C_NEXT,       0,           1'b0);
      5'd25:   w = uw(OP_DIV_STEP,   C_CNT_MORE,   L_DIVN_LOOP, 1'b0);
      5'd26:   w = uw(OP_DIVN_DONE,  C_NEXT,       0,           1'b0);
      5'd27:   w = uw(OP_DIVD_INIT,  C_NEXT,       0,           1'b0);
      5'd28:   w = uw(OP_DIV_STEP,   C_CNT_MORE,   L_DIVD_LOOP, 1'b0);
      5'd29:   w = uw(OP_DIVD_DONE,  C_NEXT,       0,           1'b1);
      default: w = uw(OP_NOP,        C_NEXT,       0,           1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/fmr_req_if.sv =====
// Command channel interface: valid/ready handshake with the command payload.
interface fmr_req_if;
  import fmr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [OPNUM_W-1:0] operand_numerator;
  logic [OPDEN_W-1:0]        operand_denominator;

  modport source (output valid, output command, output operand_numerator,
                  output operand_denominator, input ready);
  modport sink   (input valid, input command, input operand_numerator,
                  input operand_denominator, output ready);
endinterface

// ===== hw/rtl/fmr_rsp_if.sv =====
// Result channel interface: valid/ready handshake with the stored fraction payload.
interface fmr_rsp_if;
  import fmr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_numerator;
  logic [RES_W-1:0]        result_denominator;
  logic                    can_reduce;
  logic                    overflowed;

  modport source (output valid, output result_numerator, output result_denominator,
                  output can_reduce, output overflowed, input ready);
  modport sink   (input valid, input result_numerator, input result_denominator,
                  input can_reduce, input overflowed, output ready);
endinterface

// ===== hw/rtl/fmr_datapath.sv =====
// Fraction registers with a bit-serial multiplier and a restoring divider.
module fmr_datapath #(
  parameter int VALUE_WIDTH = fmr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fmr_pkg::dp_ctrl_t                  ctrl,
  input  logic signed [fmr_pkg::OPNUM_W-1:0] operand_numerator,
  input  logic [fmr_pkg::OPDEN_W-1:0]        operand_denominator,
  output fmr_pkg::dp_status_t                status,
  output logic [VALUE_WIDTH-1:0]             numerator,
  output logic [VALUE_WIDTH-1:0]             denominator,
  output logic                               mark,
  output logic                               overflowed
);
  import fmr_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};

  // Latched operands, wrapped to the register width.
  logic [W-1:0] opnum;
  logic [W-1:0] oden;
  // Gcd operands, divider and multiplier working registers.
  logic [W-1:0]   a;
  logic [W-1:0]   b;
  logic [W-1:0]   rem;
  logic [W-1:0]   dvd;
  logic [W-1:0]   dvs;
  logic [2*W-1:0] acc;
  logic [2*W-1:0] mcand;
  logic [W-1:0]   mplier;
  logic [CW-1:0]  cnt;

  logic [63:0]    opnum_ext;
  logic [63:0]    oden_ext;
  logic [W-1:0]   num_mag;
  logic [W-1:0]   opnum_mag;
  logic [W:0]     trial;
  logic [W:0]     diff;
  logic [W-1:0]   prod_hi;
  logic [W-1:0]   prod_lo;
  logic           prod_neg;
  logic [W-1:0]   prod_lim;
  logic [W-1:0]   quo_signed;

  // Operand wrapping and magnitudes.
  assign opnum_ext = {{32{operand_numerator[OPNUM_W-1]}}, operand_numerator};
  assign oden_ext  = {33'd0, operand_denominator};
  assign num_mag   = numerator[W-1] ? (~numerator + 1'b1) : numerator;
  assign opnum_mag = opnum[W-1] ? (~opnum + 1'b1) : opnum;

  // One restoring division step.
  assign trial = {rem, dvd[W-1]};
  assign diff  = trial - {1'b0, dvs};

  // Product checks after the multiplier has run.
  assign prod_hi    = acc[2*W-1:W];
  assign prod_lo    = acc[W-1:0];
  assign prod_neg   = (numerator[W-1] ^ opnum[W-1]) && (acc != '0);
  assign prod_lim   = prod_neg ? SIGN : SIGN - 1'b1;
  assign quo_signed = numerator[W-1] ? (~dvd + 1'b1) : dvd;

  // Status for the sequencer's jump conditions.
  assign status.a_zero   = (a == '0);
  assign status.b_zero   = (b == '0);
  assign status.cnt_more = (cnt > CW'(1));
  assign status.mark     = mark;

  // Architectural fraction state and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      numerator   <= '0;
      denominator <= W'(1);
      mark        <= 1'b0;
      overflowed  <= 1'b0;
    end else if (ctrl.accept) begin
      overflowed <= 1'b0;
    end else if (ctrl.run) begin
      unique case (ctrl.op)
        OP_LOAD: begin
          numerator   <= opnum;
          denominator <= oden;
        end
        OP_SET_MARK:   mark <= (a > W'(1));
        OP_CLEAR_MARK: mark <= 1'b0;
        OP_MULN_DONE: begin
          overflowed <= overflowed | (prod_hi != '0) | (prod_lo > prod_lim);
          numerator  <= prod_neg ? (~prod_lo + 1'b1) : prod_lo;
        end
        OP_MULD_DONE: begin
          overflowed  <= overflowed | (prod_hi != '0);
          denominator <= prod_lo;
        end
        OP_DIVN_DONE: numerator   <= quo_signed;
        OP_DIVD_DONE: denominator <= dvd;
        default: ;
      endcase
    end
  end

  // Working registers of the shared arithmetic units.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      opnum <= opnum_ext[W-1:0];
      oden  <= oden_ext[W-1:0];
    end else if (ctrl.run) begin
      unique case (ctrl.op)
        OP_GCD_INIT: begin
          if (numerator == '0) begin
            a <= denominator;
            b <= '0;
          end else begin
            a <= num_mag;
            b <= denominator;
          end
        end
        OP_DIVG_INIT: begin
          dvd <= a;
          dvs <= b;
          rem <= '0;
          cnt <= CW'(W);
        end
        OP_DIVN_INIT: begin
          dvd <= num_mag;
          dvs <= a;
          rem <= '0;
          cnt <= CW'(W);
        end
        OP_DIVD_INIT: begin
          dvd <= denominator;
          dvs <= a;
          rem <= '0;
          cnt <= CW'(W);
        end
        OP_DIV_STEP: begin
          if (!diff[W]) begin
            rem <= diff[W-1:0];
            dvd <= {dvd[W-2:0], 1'b1};
          end else begin
            rem <= trial[W-1:0];
            dvd <= {dvd[W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
        end
        OP_GCD_SHIFT: begin
          a <= b;
          b <= rem;
        end
        OP_MULN_INIT: begin
          mcand  <= {{W{1'b0}}, num_mag};
          mplier <= opnum_mag;
          acc    <= '0;
          cnt    <= CW'(W);
        end
        OP_MULD_INIT: begin
          mcand  <= {{W{1'b0}}, denominator};
          mplier <= oden;
          acc    <= '0;
          cnt    <= CW'(W);
        end
        OP_MUL_STEP: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= {mcand[2*W-2:0], 1'b0};
          mplier <= {1'b0, mplier[W-1:1]};
          cnt    <= cnt - 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/fraction_multiply_reduce.sv =====
// A multiply of a marked fraction skips the gcd, a reduce of an unmarked fraction does no work,
// and a marked reduce whose gcd is zero divides nothing. Each gcd runs Euclid iterations as
// needed; one bit-serial multiplier and one restoring divider are shared by all commands.
// Throughput: one command at a time; the next is taken once the result is registered.
// Reset: synchronous; the fraction becomes 0/1, unmarked, and no result is pending.
module fraction_multiply_reduce #(
  parameter int VALUE_WIDTH = fmr_pkg::VALUE_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  fmr_req_if.sink   request,
  fmr_rsp_if.source response
);
  import fmr_pkg::*;

  localparam int W = VALUE_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t          state;
  logic [PC_W-1:0] pc;
  ucode_t          uc;
  logic            jump;
  dp_ctrl_t        ctrl;
  dp_status_t      status;
  logic            accept;
  logic            out_free;

  logic [W-1:0]       numerator;
  logic [W-1:0]       denominator;
  logic               mark;
  logic               overflowed;
  logic signed [63:0] num_ext;
  logic [63:0]        den_ext;

  // Handshake and control word fetch.
  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign out_free      = !response.valid || response.ready;
  assign uc            = ucode(pc);

  assign ctrl.accept = accept;
  assign ctrl.run    = (state == S_RUN);
  assign ctrl.op     = uc.op;

  // Jump condition of the current step.
  always_comb begin
    unique case (uc.cond)
      C_ALWAYS:     jump = 1'b1;
      C_CNT_MORE:   jump = status.cnt_more;
      C_A_ZERO:     jump = status.a_zero;
      C_B_ZERO:     jump = status.b_zero;
      C_MARK_SET:   jump = status.mark;
      C_MARK_CLEAR: jump = !status.mark;
      default:      jump = 1'b0;
    endcase
  end

  // Sequencer: dispatch on the command, step the program, then report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            unique case (cmd_t'(request.command))
              CMD_LOAD:   pc <= PC_W'(L_LOAD);
              CMD_MUL:    pc <= PC_W'(L_MUL);
              CMD_REDUCE: pc <= PC_W'(L_RED);
              CMD_NONE:   pc <= PC_W'(L_DONE);
            endcase
          end
        end
        S_RUN: begin
          if (uc.last) begin
            state <= S_REPORT;
          end else if (jump) begin
            pc <= uc.target;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        S_REPORT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  fmr_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .ctrl                (ctrl),
    .operand_numerator   (request.operand_numerator),
    .operand_denominator (request.operand_denominator),
    .status              (status),
    .numerator           (numerator),
    .denominator         (denominator),
    .mark                (mark),
    .overflowed          (overflowed)
  );

  // Result fields widened or cut to the transaction width.
  assign num_ext = 64'(signed'(numerator));
  assign den_ext = 64'(denominator);

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (state == S_REPORT && out_free) begin
      response.valid <= 1'b1;
    end else if (response.ready) begin
      response.valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (state == S_REPORT && out_free) begin
      response.result_numerator   <= num_ext[RES_W-1:0];
      response.result_denominator <= den_ext[RES_W-1:0];
      response.can_reduce         <= mark;
      response.overflowed         <= overflowed;
    end
  end

endmodule
